@@ design/geiger_sliding_window_counter_top_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the sliding window counter
// Shared property forms used by the port checker.
// ---------------------------------------------------------------------------
`ifndef GEIGER_SLIDING_WINDOW_COUNTER_TOP_MACROS_SVH
`define GEIGER_SLIDING_WINDOW_COUNTER_TOP_MACROS_SVH

// same-cycle implication, disabled in reset
`define GSW_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define GSW_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/gsw_pkg.sv @@
// ---------------------------------------------------------------------------
// gsw_pkg
// Types and constants shared by the sliding window counter modules.
// ---------------------------------------------------------------------------
package gsw_pkg;

  localparam int unsigned HISTORY_DEPTH_DEF = 200;
  localparam int unsigned JOB_QUEUE_DEPTH   = 4;

  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 104;
  localparam int unsigned CFG_DATA_W  = 16;

  // configuration register indexes
  localparam logic [1:0] CFG_WINDOW_ITEMS   = 2'd0;
  localparam logic [1:0] CFG_BUCKET_SECONDS = 2'd1;
  localparam logic [1:0] CFG_MAX_COUNT      = 2'd2;

  localparam logic [15:0] WINDOW_ITEMS_RST   = 16'd10000;
  localparam logic [5:0]  BUCKET_SECONDS_RST = 6'd6;
  localparam logic [11:0] MAX_COUNT_RST      = 12'd1200;

  localparam logic [11:0] SECONDS_PER_HOUR = 12'd3600;
  localparam logic [31:0] MS_PER_SECOND    = 32'd1000;
  localparam logic [15:0] BUCKET_MAX       = 16'hFFFF;
  localparam logic [23:0] SUM_MAX          = 24'hFFFFFF;

  typedef struct packed {
    logic        we;
    logic [1:0]  idx;
    logic [15:0] data;
  } cfg_wr_t;

  // one noise-free closed window handed to the back end
  typedef struct packed {
    logic [15:0] tally;
    logic [31:0] elapsed;
  } job_t;

  typedef struct packed {
    logic [11:0] count_time_seconds;
    logic [23:0] count_sum;
    logic [15:0] window_pulses;
    logic [15:0] ms_fraction;
    logic [11:0] total_seconds;
    logic [19:0] total_hours;
  } result_t;

  typedef struct packed {
    logic        start;
    logic [11:0] dividend;
    logic [5:0]  divisor;
  } mod_req_t;

  typedef struct packed {
    logic       busy;
    logic       done;
    logic [5:0] rem;
  } mod_stat_t;

endpackage

@@ design/gsw_front.sv @@
// ---------------------------------------------------------------------------
// gsw_front
// Accepts samples, tracks noise edges, pulse tally and the window counter,
// and queues a job for every noise-free window that closes.
// ---------------------------------------------------------------------------
module gsw_front import gsw_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_wr_t     cfg,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic        noise_level,
  input  logic [1:0]  pulse_count,
  input  logic [31:0] now_ms,
  input  logic        q_full,
  output logic        q_push,
  output job_t        q_job
);

  logic [15:0] wi_r, wi_nxt;
  logic [15:0] lc_r, lc_nxt;
  logic        latch_r, latch_nxt;
  logic        seen_r, seen_nxt;
  logic [15:0] tally_r, tally_nxt;
  logic [31:0] prev_r, prev_nxt;

  logic        accept;
  logic        seen_now;
  logic        close;
  logic [16:0] tally_sum;
  logic [15:0] tally_sat;

  assign in_tready = !q_full;

  always_comb begin
    accept    = in_tvalid && in_tready;
    seen_now  = seen_r | (noise_level & ~latch_r);
    tally_sum = {1'b0, tally_r} + 17'(pulse_count);
    tally_sat = tally_sum[16] ? BUCKET_MAX : tally_sum[15:0];
    close     = (lc_r == wi_r);

    q_push        = accept && close && !seen_now;
    q_job.tally   = tally_sat;
    q_job.elapsed = now_ms - prev_r;

    wi_nxt    = wi_r;
    lc_nxt    = lc_r;
    latch_nxt = latch_r;
    seen_nxt  = seen_r;
    tally_nxt = tally_r;
    prev_nxt  = prev_r;

    if (cfg.we && cfg.idx == CFG_WINDOW_ITEMS) begin
      wi_nxt = cfg.data;
    end

    if (accept) begin
      latch_nxt = noise_level;
      if (close) begin
        // restart the window whether or not it was noisy
        prev_nxt  = now_ms;
        tally_nxt = '0;
        seen_nxt  = 1'b0;
        lc_nxt    = 16'd1;
      end else begin
        tally_nxt = tally_sat;
        seen_nxt  = seen_now;
        lc_nxt    = lc_r + 16'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wi_r    <= WINDOW_ITEMS_RST;
      lc_r    <= '0;
      latch_r <= 1'b0;
      seen_r  <= 1'b0;
      tally_r <= '0;
      prev_r  <= '0;
    end else begin
      wi_r    <= wi_nxt;
      lc_r    <= lc_nxt;
      latch_r <= latch_nxt;
      seen_r  <= seen_nxt;
      tally_r <= tally_nxt;
      prev_r  <= prev_nxt;
    end
  end

endmodule

@@ design/gsw_fifo.sv @@
// ---------------------------------------------------------------------------
// gsw_fifo
// Small job queue between the front and back ends.
// ---------------------------------------------------------------------------
module gsw_fifo import gsw_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output logic empty,
  output logic full,
  output job_t head
);

  localparam int unsigned PTR_W = $clog2(JOB_QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(JOB_QUEUE_DEPTH + 1);

  job_t             entry_r [JOB_QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == CNT_W'(JOB_QUEUE_DEPTH));
  assign head  = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(JOB_QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(JOB_QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

@@ design/gsw_mod.sv @@
// ---------------------------------------------------------------------------
// gsw_mod
// Bit-serial remainder unit: seconds of the hour modulo bucket length,
// one dividend bit per cycle.
// ---------------------------------------------------------------------------
module gsw_mod import gsw_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  mod_req_t  req,
  output mod_stat_t stat
);

  localparam int unsigned STEPS = $bits(req.dividend);
  localparam int unsigned CNT_W = $clog2(STEPS);

  logic             run_r, run_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [STEPS-1:0] dvd_r, dvd_nxt;
  logic [5:0]       rem_r, rem_nxt;
  logic [5:0]       dsr_r, dsr_nxt;
  logic [6:0]       trial;

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    trial    = {rem_r, dvd_r[STEPS-1]};

    if (req.start) begin
      run_nxt = 1'b1;
      cnt_nxt = '0;
      dvd_nxt = req.dividend;
      rem_nxt = '0;
      // a zero bucket length acts as one
      dsr_nxt = (req.divisor == '0) ? 6'd1 : req.divisor;
    end else if (run_r) begin
      dvd_nxt = {dvd_r[STEPS-2:0], 1'b0};
      if (trial >= {1'b0, dsr_r}) begin
        rem_nxt = 6'(trial - {1'b0, dsr_r});
      end else begin
        rem_nxt = trial[5:0];
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(STEPS - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign stat.busy = req.start | run_r | done_r;
  assign stat.done = done_r;
  assign stat.rem  = rem_r;

endmodule

@@ design/gsw_back.sv @@
// ---------------------------------------------------------------------------
// gsw_back
// Window bookkeeping: bucket ring roll, running sum, time accumulation,
// hour wrap, and the registered result stage.
// ---------------------------------------------------------------------------
module gsw_back import gsw_pkg::*; #(
  parameter int unsigned HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_wr_t   cfg,
  input  logic      job_valid,
  input  job_t      job,
  output logic      job_pop,
  output mod_req_t  mod_req,
  input  mod_stat_t mod_stat,
  output logic      out_tvalid,
  input  logic      out_tready,
  output result_t   res
);

  localparam int unsigned PTR_W = $clog2(HISTORY_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(HISTORY_DEPTH - 1);

  logic [15:0] ring_mem [HISTORY_DEPTH];

  logic [5:0]       bs_r, bs_nxt;
  logic [11:0]      max_r, max_nxt;
  logic             start_r, start_nxt;
  logic [PTR_W-1:0] ptr_r, ptr_nxt;
  logic             wrapped_r, wrapped_nxt;
  logic [15:0]      cur_r, cur_nxt;
  logic [23:0]      sum_r, sum_nxt;
  logic [31:0]      acc_r, acc_nxt;
  logic [11:0]      cs_r, cs_nxt;
  logic [11:0]      sih_r, sih_nxt;
  logic [19:0]      hour_r, hour_nxt;
  logic [11:0]      last_r, last_nxt;
  logic [5:0]       phase_r, phase_nxt;
  logic             rd_ok_r;
  logic             rd_live_r;
  logic [15:0]      rd_data_r;
  logic             out_valid_r, out_valid_nxt;
  result_t          res_r, res_nxt;

  logic             fire;
  logic             roll;
  logic             tick;
  logic             hour_wrap;
  logic [PTR_W-1:0] ptr_ahead;
  logic [5:0]       bs_eff;
  logic [6:0]       phase_inc;
  logic [15:0]      next_old;
  logic [15:0]      old;
  logic [23:0]      sum_a;
  logic [16:0]      bucket_add;
  logic [15:0]      nv;
  logic [24:0]      sum_add;
  logic [32:0]      acc_add;
  logic [31:0]      acc_sat;
  logic [11:0]      sih_inc;

  always_comb begin
    ptr_ahead = (ptr_r == PTR_LAST) ? '0 : ptr_r + 1'b1;
    bs_eff    = (bs_r == '0) ? 6'd1 : bs_r;
    next_old  = rd_live_r ? rd_data_r : 16'd0;

    fire    = job_valid && rd_ok_r && !mod_stat.busy && (!out_valid_r || out_tready);
    job_pop = fire;

    roll  = (phase_r == '0) && (last_r != sih_r);
    old   = roll ? 16'd0 : cur_r;
    sum_a = sum_r;
    if (roll) begin
      sum_a = (sum_r >= {8'd0, next_old}) ? sum_r - {8'd0, next_old} : 24'd0;
    end

    bucket_add = {1'b0, old} + {1'b0, job.tally};
    nv         = bucket_add[16] ? BUCKET_MAX : bucket_add[15:0];
    sum_add    = {1'b0, sum_a} + {9'd0, 16'(nv - old)};

    acc_add = {1'b0, acc_r} + {1'b0, job.elapsed};
    acc_sat = acc_add[32] ? 32'hFFFF_FFFF : acc_add[31:0];
    tick    = (acc_sat >= MS_PER_SECOND);

    sih_inc   = sih_r + 12'd1;
    hour_wrap = tick && (sih_inc == SECONDS_PER_HOUR);
    phase_inc = {1'b0, phase_r} + 7'd1;

    bs_nxt        = bs_r;
    max_nxt       = max_r;
    start_nxt     = 1'b0;
    ptr_nxt       = ptr_r;
    wrapped_nxt   = wrapped_r;
    cur_nxt       = cur_r;
    sum_nxt       = sum_r;
    acc_nxt       = acc_r;
    cs_nxt        = cs_r;
    sih_nxt       = sih_r;
    hour_nxt      = hour_r;
    last_nxt      = last_r;
    phase_nxt     = phase_r;
    out_valid_nxt = out_valid_r && !out_tready;
    res_nxt       = res_r;

    if (cfg.we) begin
      case (cfg.idx)
        CFG_BUCKET_SECONDS: begin
          bs_nxt    = cfg.data[5:0];
          start_nxt = 1'b1;
        end
        CFG_MAX_COUNT: max_nxt = cfg.data[11:0];
        default: ;
      endcase
    end

    // recomputed bucket phase after a bucket length change
    if (mod_stat.done) begin
      phase_nxt = mod_stat.rem;
    end

    if (fire) begin
      if (roll) begin
        ptr_nxt  = ptr_ahead;
        last_nxt = sih_r;
        if (ptr_r == PTR_LAST) begin
          wrapped_nxt = 1'b1;
        end
      end
      cur_nxt = nv;
      sum_nxt = sum_add[24] ? SUM_MAX : sum_add[23:0];
      acc_nxt = tick ? acc_sat - MS_PER_SECOND : acc_sat;
      if (tick) begin
        cs_nxt = (cs_r >= max_r) ? max_r : cs_r + 12'd1;
        if (hour_wrap) begin
          sih_nxt   = '0;
          hour_nxt  = hour_r + 20'd1;
          phase_nxt = '0;
        end else begin
          sih_nxt   = sih_inc;
          phase_nxt = (phase_inc == {1'b0, bs_eff}) ? 6'd0 : phase_inc[5:0];
        end
      end

      out_valid_nxt              = 1'b1;
      res_nxt.total_hours        = hour_nxt;
      res_nxt.total_seconds      = sih_nxt;
      res_nxt.ms_fraction        = (acc_nxt[31:16] != '0) ? 16'hFFFF : acc_nxt[15:0];
      res_nxt.window_pulses      = job.tally;
      res_nxt.count_sum          = sum_nxt;
      res_nxt.count_time_seconds = cs_nxt;
    end
  end

  assign mod_req.start    = start_r;
  assign mod_req.dividend = sih_r;
  assign mod_req.divisor  = bs_r;

  // ring: current bucket write, read-ahead of the next bucket
  always_ff @(posedge clk) begin
    if (fire) begin
      ring_mem[ptr_nxt] <= nv;
    end
    rd_data_r <= ring_mem[ptr_ahead];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bs_r        <= BUCKET_SECONDS_RST;
      max_r       <= MAX_COUNT_RST;
      start_r     <= 1'b0;
      ptr_r       <= '0;
      wrapped_r   <= 1'b0;
      cur_r       <= '0;
      sum_r       <= '0;
      acc_r       <= '0;
      cs_r        <= '0;
      sih_r       <= '0;
      hour_r      <= '0;
      last_r      <= '0;
      phase_r     <= '0;
      rd_ok_r     <= 1'b0;
      rd_live_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      bs_r        <= bs_nxt;
      max_r       <= max_nxt;
      start_r     <= start_nxt;
      ptr_r       <= ptr_nxt;
      wrapped_r   <= wrapped_nxt;
      cur_r       <= cur_nxt;
      sum_r       <= sum_nxt;
      acc_r       <= acc_nxt;
      cs_r        <= cs_nxt;
      sih_r       <= sih_nxt;
      hour_r      <= hour_nxt;
      last_r      <= last_nxt;
      phase_r     <= phase_nxt;
      // drop the read-ahead for one cycle after the pointer moves
      rd_ok_r     <= !(fire && roll);
      // entries ahead of the pointer are unwritten until it has wrapped
      rd_live_r   <= wrapped_r || (ptr_r == PTR_LAST);
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign res        = res_r;

endmodule

@@ design/geiger_sliding_window_counter_top.sv @@
// ---------------------------------------------------------------------------
// geiger_sliding_window_counter_top
// Sliding window radiation counter: samples in, one status result per
// noise-free closed window out.
// ---------------------------------------------------------------------------
//  Channel | Direction | Handshake          | Payload
//  in_     | input     | in_tvalid/tready   | in_tdata  : sample (40 bits)
//  out_    | output    | out_tvalid/tready  | out_tdata : status (104 bits)
//  cfg_    | input     | cfg_we             | cfg_index, cfg_wdata
//
//  One sample is taken per cycle; the front end never waits on the result
//  side except when the 4-entry job queue is full.
//  The back end retires one closed window per cycle while the result side
//  keeps up; a window that advances the bucket pointer stalls the back end
//  while the ring read-ahead is refetched. A bucket_seconds write holds the
//  back end while the 12-step remainder unit recomputes the bucket phase.
//  Reset is synchronous and needs no clearing pass: ring entries not yet
//  reached by the pointer read as zero until it first wraps.
// ---------------------------------------------------------------------------
module geiger_sliding_window_counter_top import gsw_pkg::*; #(
  parameter int unsigned HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // noise_level[0], pulse_count[2:1], now_ms[34:3], zero pad
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // total_hours[19:0], total_seconds[31:20], ms_fraction[47:32],
  // window_pulses[63:48], count_sum[87:64], count_time_seconds[99:88], zero pad
  output logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  cfg_wr_t   cfg;
  logic      q_push;
  job_t      q_job;
  logic      q_full;
  logic      q_empty;
  job_t      q_head;
  logic      q_pop;
  mod_req_t  mod_req;
  mod_stat_t mod_stat;
  result_t   res;

  assign cfg.we   = cfg_we;
  assign cfg.idx  = cfg_index;
  assign cfg.data = cfg_wdata;

  gsw_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .noise_level (in_tdata[0]),
    .pulse_count (in_tdata[2:1]),
    .now_ms      (in_tdata[34:3]),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_job       (q_job)
  );

  gsw_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_job),
    .pop      (q_pop),
    .empty    (q_empty),
    .full     (q_full),
    .head     (q_head)
  );

  gsw_mod u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mod_req),
    .stat  (mod_stat)
  );

  gsw_back #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .job_valid  (!q_empty),
    .job        (q_head),
    .job_pop    (q_pop),
    .mod_req    (mod_req),
    .mod_stat   (mod_stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .res        (res)
  );

  assign out_tdata = {4'd0, res.count_time_seconds, res.count_sum, res.window_pulses,
                      res.ms_fraction, res.total_seconds, res.total_hours};

endmodule

@@ design/gsw_checker.sv @@
// ---------------------------------------------------------------------------
// gsw_checker
// Port-level checks on the result stream of the sliding window counter.
// ---------------------------------------------------------------------------
`include "geiger_sliding_window_counter_top_macros.svh"

module gsw_checker import gsw_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic [IN_TDATA_W-1:0]  in_tdata,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   cfg_we,
  input logic [1:0]             cfg_index,
  input logic [CFG_DATA_W-1:0]  cfg_wdata
);

  logic [11:0] out_sec;
  logic        out_xfer;

  assign out_sec  = out_tdata[31:20];
  assign out_xfer = out_tvalid && out_tready;

  // hold a stalled result
  `GSW_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled result changed")

  `GSW_ASSERT_IMP(a_sec_range, out_tvalid, out_sec < SECONDS_PER_HOUR, "seconds of hour out of range")

  // consecutive results advance the clock by at most one second
  `GSW_ASSERT_IMP(a_sec_step, out_xfer && $past(out_xfer), (out_sec == $past(out_sec)) || (out_sec == $past(out_sec) + 12'd1) || (out_sec == 12'd0), "seconds jumped between results")

endmodule

bind geiger_sliding_window_counter_top gsw_checker u_gsw_checker (.*);

@@ tb/tb_geiger_sliding_window_counter_top.sv @@
// ---------------------------------------------------------------------------
// tb_geiger_sliding_window_counter_top
// Self-checking bench for the sliding window counter. Streams sensor samples
// under several register settings and handshake patterns, predicts every
// status result from its own copy of the window, time and bucket state, and
// compares each result field by field in arrival order.
// ---------------------------------------------------------------------------
module tb_geiger_sliding_window_counter_top import gsw_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH          = HISTORY_DEPTH_DEF;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned SETTLE_CYCLES  = 40;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned NOISE_PCT      = 8;
  localparam logic [1:0]  CFG_SPARE_IDX  = 2'd3;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  // noise_level[0], pulse_count[2:1], now_ms[34:3], zero pad
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // total_hours[19:0], total_seconds[31:20], ms_fraction[47:32],
  // window_pulses[63:48], count_sum[87:64], count_time_seconds[99:88], zero pad
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_we     = 1'b0;
  logic [1:0]             cfg_index  = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata  = '0;

  // handshake shaping
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_calls     = 0;
  int unsigned hold_served    = 0;
  int unsigned hold_left      = 0;
  int unsigned quiet_cycles   = 0;
  int unsigned mismatch_count = 0;
  logic [31:0] clock_ms       = '0;

  // predicted block state
  logic [15:0] cfg_window   = WINDOW_ITEMS_RST;
  logic [5:0]  cfg_bucket_s = BUCKET_SECONDS_RST;
  logic [11:0] cfg_max_s    = MAX_COUNT_RST;
  logic [15:0] win_pos      = '0;
  logic        noise_hi     = 1'b0;
  logic        window_noisy = 1'b0;
  logic [15:0] pulse_run    = '0;
  logic [31:0] last_close_ms = '0;
  logic [31:0] ms_bank      = '0;
  logic [11:0] counted_s    = '0;
  logic [11:0] hour_s       = '0;
  logic [19:0] hours        = '0;
  logic [15:0] bucket_cnt [DEPTH] = '{default: '0};
  logic [7:0]  bucket_idx   = '0;
  logic [11:0] last_roll_s  = '0;
  logic [23:0] bucket_total = '0;

  result_t status_q [$];

  geiger_sliding_window_counter_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #1 clk = ~clk;

  // Advance the predicted state by one accepted sample.
  task automatic predict_sample(input logic noise, input logic [1:0] pulses,
                                input logic [31:0] now);
    logic [5:0]  bs;
    logic [16:0] grown;
    logic [15:0] gain;
    logic [24:0] sum_next;
    logic [31:0] elapsed;
    result_t     status;
    if (noise && !noise_hi) begin
      noise_hi     = 1'b1;
      window_noisy = 1'b1;
    end else if (!noise && noise_hi) begin
      noise_hi = 1'b0;
    end
    if (pulse_run > BUCKET_MAX - pulses) pulse_run = BUCKET_MAX;
    else pulse_run = pulse_run + pulses;

    if (win_pos == cfg_window) begin
      if (!window_noisy) begin
        bs = (cfg_bucket_s == 0) ? 6'd1 : cfg_bucket_s;
        if (hour_s % bs == 0 && last_roll_s != hour_s) begin
          last_roll_s = hour_s;
          bucket_idx  = (bucket_idx == DEPTH - 1) ? 8'd0 : bucket_idx + 8'd1;
          if (bucket_total >= bucket_cnt[bucket_idx])
            bucket_total = bucket_total - bucket_cnt[bucket_idx];
          else
            bucket_total = '0;
          bucket_cnt[bucket_idx] = '0;
        end
        grown = bucket_cnt[bucket_idx] + pulse_run;
        if (grown > BUCKET_MAX) grown = BUCKET_MAX;
        gain = grown[15:0] - bucket_cnt[bucket_idx];
        bucket_cnt[bucket_idx] = grown[15:0];
        sum_next = bucket_total + gain;
        bucket_total = (sum_next > SUM_MAX) ? SUM_MAX : sum_next[23:0];

        elapsed = now - last_close_ms;
        if (ms_bank > 32'hFFFF_FFFF - elapsed) ms_bank = 32'hFFFF_FFFF;
        else ms_bank = ms_bank + elapsed;
        // at most one second leaves the bank per window
        if (ms_bank >= MS_PER_SECOND) begin
          ms_bank   = ms_bank - MS_PER_SECOND;
          counted_s = (counted_s >= cfg_max_s) ? cfg_max_s : counted_s + 12'd1;
          hour_s    = hour_s + 12'd1;
          if (hour_s >= SECONDS_PER_HOUR) begin
            hour_s = hour_s - SECONDS_PER_HOUR;
            hours  = hours + 20'd1;
          end
        end

        status.total_hours        = hours;
        status.total_seconds      = hour_s;
        status.ms_fraction        = (ms_bank > 32'h0000_FFFF) ? 16'hFFFF : ms_bank[15:0];
        status.window_pulses      = pulse_run;
        status.count_sum          = bucket_total;
        status.count_time_seconds = counted_s;
        status_q.push_back(status);
      end
      last_close_ms = now;
      pulse_run     = '0;
      window_noisy  = 1'b0;
      win_pos       = '0;
    end
    win_pos = win_pos + 16'd1;
  endtask

  // One sample transaction; step advances the millisecond timestamp.
  task automatic send_sample(input logic noise, input logic [1:0] pulses,
                             input logic [31:0] step);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    clock_ms = clock_ms + step;
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_TDATA_W - 35){1'b0}}, clock_ms, pulses, noise};
    do @(posedge clk); while (!in_tready);
    predict_sample(noise, pulses, clock_ms);
  endtask

  // Write all registers; upper data bits beyond each register carry junk.
  task automatic set_config(input logic [15:0] win, input logic [5:0] bkt,
                            input logic [11:0] maxc);
    logic [15:0] junk;
    junk = $urandom;
    cfg_we    <= 1'b1;
    cfg_index <= CFG_WINDOW_ITEMS;
    cfg_wdata <= win;
    @(posedge clk);
    cfg_index <= CFG_BUCKET_SECONDS;
    cfg_wdata <= {junk[15:6], bkt};
    @(posedge clk);
    cfg_index <= CFG_MAX_COUNT;
    cfg_wdata <= {junk[3:0], maxc};
    @(posedge clk);
    cfg_index <= CFG_SPARE_IDX;
    cfg_wdata <= junk;
    @(posedge clk);
    cfg_we       <= 1'b0;
    cfg_window   = win;
    cfg_bucket_s = bkt;
    cfg_max_s    = maxc;
  endtask

  // Finish the open window, drain all results, then let the back end go quiet.
  task automatic settle();
    while (win_pos != 16'd1)
      send_sample(1'b0, $urandom_range(3), $urandom_range(0, 400));
    in_tvalid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic test_reset_defaults();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    // first window runs one sample longer than window_items
    do send_sample(1'b0, $urandom_range(3), $urandom_range(0, 1)); while (win_pos != 16'd1);
    settle();
  endtask

  task automatic test_directed_cases();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    set_config(16'd1, 6'd1, 12'd3);
    send_sample(1'b0, 2'd3, 32'd1000);
    send_sample(1'b0, 2'd0, 32'd0);
    send_sample(1'b1, 2'd3, 32'd1000);   // rising noise edge: window dropped
    send_sample(1'b1, 2'd2, 32'd1000);   // noise still high, no new edge
    send_sample(1'b0, 2'd1, 32'd1500);
    send_sample(1'b0, 2'd3, 32'd2500);
    send_sample(1'b1, 2'd0, 32'd700);
    send_sample(1'b0, 2'd2, 32'd1000);
    settle();
    // zero bucket length acts as one
    set_config(16'd3, 6'd0, 12'd4095);
    send_sample(1'b0, 2'd1, 32'd300);
    send_sample(1'b1, 2'd2, 32'd300);    // short blip still marks the window
    send_sample(1'b0, 2'd3, 32'd300);
    // jump near the timestamp wrap inside a noisy window, then run across it
    send_sample(1'b0, 2'd0, 32'd200);
    send_sample(1'b1, 2'd1, 32'hFFFF_FE00 - clock_ms);
    send_sample(1'b0, 2'd2, 32'd16);
    repeat (6) send_sample(1'b0, 2'd3, 32'd400);
    settle();
  endtask

  task automatic test_hour_rollover();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    set_config(16'd1, 6'd1, 12'd4095);
    repeat (4200) send_sample(1'b0, $urandom_range(3), $urandom_range(1000, 1010));
    settle();
  endtask

  task automatic test_random_traffic(input int unsigned idle_pct,
                                     input int unsigned stall_pct,
                                     input logic [5:0] bkt, input logic [11:0] maxc,
                                     input int unsigned count);
    logic [15:0] win;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    win = ($urandom_range(3) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
    set_config(win, bkt, maxc);
    repeat (count)
      send_sample($urandom_range(99) < NOISE_PCT, $urandom_range(3), $urandom_range(0, 700));
    settle();
  endtask

  task automatic test_output_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    set_config(16'd1, 6'd5, 12'd600);
    hold_calls = hold_calls + 1;
    repeat (60) send_sample(1'b0, $urandom_range(3), $urandom_range(900, 1100));
    settle();
  endtask

  // Largest window, then window_items of zero, which needs a counter wrap.
  task automatic test_long_windows();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    for (int pass = 0; pass < 2; pass++) begin
      set_config((pass == 0) ? 16'hFFFF : 16'd0, 6'd63, 12'd2000);
      do send_sample(1'b0, 2'd3, ($urandom_range(63) == 0)); while (win_pos != 16'd1);
      settle();
    end
  endtask

  task automatic test_time_saturation();
    send_idle_pct  = 35;
    recv_stall_pct = 35;
    set_config($urandom_range(1, 4), $urandom_range(1, 63), $urandom_range(1, 4095));
    repeat (80) send_sample($urandom_range(99) < NOISE_PCT, $urandom_range(3), $urandom);
    settle();
  endtask

  // Receiver: random stalls, plus a long hold-off on request.
  always @(posedge clk) begin
    if (hold_calls != hold_served) begin
      hold_served <= hold_calls;
      hold_left   <= HOLD_CYCLES;
      out_tready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic flag_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] seen);
    mismatch_count = mismatch_count + 1;
    if (mismatch_count <= 10)
      $display("mismatch %s: expected %0d, got %0d", what, want, seen);
  endtask

  always @(posedge clk) begin
    result_t want;
    result_t seen;
    if (rst_n && out_tvalid && out_tready) begin
      seen = out_tdata[$bits(result_t)-1:0];
      if (status_q.size() == 0) begin
        flag_mismatch("unexpected status", 32'd0, seen.total_seconds);
      end else begin
        want = status_q.pop_front();
        if (seen.total_hours !== want.total_hours)
          flag_mismatch("total_hours", want.total_hours, seen.total_hours);
        if (seen.total_seconds !== want.total_seconds)
          flag_mismatch("total_seconds", want.total_seconds, seen.total_seconds);
        if (seen.ms_fraction !== want.ms_fraction)
          flag_mismatch("ms_fraction", want.ms_fraction, seen.ms_fraction);
        if (seen.window_pulses !== want.window_pulses)
          flag_mismatch("window_pulses", want.window_pulses, seen.window_pulses);
        if (seen.count_sum !== want.count_sum)
          flag_mismatch("count_sum", want.count_sum, seen.count_sum);
        if (seen.count_time_seconds !== want.count_time_seconds)
          flag_mismatch("count_time_seconds", want.count_time_seconds,
                        seen.count_time_seconds);
      end
      if (out_tdata[OUT_TDATA_W-1:$bits(result_t)] !== '0)
        flag_mismatch("pad bits", 32'd0, out_tdata[OUT_TDATA_W-1:$bits(result_t)]);
    end
  end

  // Watchdog: stop when no transaction moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_directed_cases();
    test_hour_rollover();
    test_random_traffic(0, 0, 6'd0, 12'd1, 180);
    test_random_traffic(55, 0, 6'd60, 12'd4095, 180);
    test_random_traffic(0, 55, 6'd63, $urandom_range(1, 4095), 180);
    test_random_traffic(35, 35, $urandom_range(2, 59), $urandom_range(1, 4095), 180);
    test_output_backpressure();
    test_long_windows();
    test_time_saturation();
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
